FILE: sv/fmpf_pkg.sv
// Package for the first-match packet filter: field widths, bit offsets of
// the stream payloads, protocol and command codes, and the shared structs.
// No dependencies.
`default_nettype none

package fmpf_pkg;

   // Default number of rule cells in the chain.
   localparam int unsigned RuleSlotsDef = 16;

   // Field widths.
   localparam int unsigned RuleIndexW = 4;
   localparam int unsigned ActionW    = 2;
   localparam int unsigned AddressW   = 32;
   localparam int unsigned ProtocolW  = 4;
   localparam int unsigned IcmpW      = 9;
   localparam int unsigned PortW      = 16;
   localparam int unsigned FlagsW     = 16;
   localparam int unsigned FlagByteW  = 8;
   localparam int unsigned RuleHitW   = 4;
   localparam int unsigned CountW     = 5;
   // Width used when comparing a cell number with the rule count.
   localparam int unsigned CountCmpW  = 9;

   // Bit offsets inside the request tdata, lowest field first.
   localparam int unsigned OffRuleIndex = 0;
   localparam int unsigned OffAction    = OffRuleIndex + RuleIndexW;
   localparam int unsigned OffCheck     = OffAction + ActionW;
   localparam int unsigned OffAddress   = OffCheck + 1;
   localparam int unsigned OffProtocol  = OffAddress + AddressW;
   localparam int unsigned OffIcmp      = OffProtocol + ProtocolW;
   localparam int unsigned OffSrcFirst  = OffIcmp + IcmpW;
   localparam int unsigned OffSrcLast   = OffSrcFirst + PortW;
   localparam int unsigned OffDstFirst  = OffSrcLast + PortW;
   localparam int unsigned OffDstLast   = OffDstFirst + PortW;
   localparam int unsigned OffFlags     = OffDstLast + PortW;
   localparam int unsigned ReqUsedW     = OffFlags + FlagsW;
   localparam int unsigned ReqDataW     = ((ReqUsedW + 7) / 8) * 8;

   // Response tdata: verdict, matched, rule_hit, then zero padding.
   localparam int unsigned RspUsedW = ActionW + 1 + RuleHitW;
   localparam int unsigned RspDataW = ((RspUsedW + 7) / 8) * 8;

   // Command carried in tuser.
   typedef enum logic {
      CMD_WRITE   = 1'b0,
      CMD_INSPECT = 1'b1
   } cmd_type;

   // Protocol codes.
   localparam logic [ProtocolW-1:0] ProtoAny  = 4'd0;
   localparam logic [ProtocolW-1:0] ProtoTcp  = 4'd1;
   localparam logic [ProtocolW-1:0] ProtoUdp  = 4'd2;
   localparam logic [ProtocolW-1:0] ProtoIcmp = 4'd3;

   // Action codes.
   localparam logic [ActionW-1:0] ActAllow  = 2'd0;
   localparam logic [ActionW-1:0] ActReject = 2'd2;
   localparam logic [ActionW-1:0] ActSpare  = 2'd3;

   // One stored rule.
   typedef struct packed {
      logic [ActionW-1:0]   action;
      logic                 check_address;
      logic [AddressW-1:0]  address;
      logic [ProtocolW-1:0] protocol;
      logic [IcmpW-1:0]     icmp_msg;
      logic [FlagByteW-1:0] flag_mask;
      logic [FlagByteW-1:0] flag_match;
      logic [PortW-1:0]     src_first;
      logic [PortW-1:0]     src_last;
      logic [PortW-1:0]     dst_first;
      logic [PortW-1:0]     dst_last;
   } rule_type;

   // Packet header as it walks the chain, already gated by protocol.
   typedef struct packed {
      logic [AddressW-1:0]  address;
      logic [ProtocolW-1:0] protocol;
      logic [IcmpW-1:0]     icmp_msg;
      logic [PortW-1:0]     sport;
      logic [PortW-1:0]     dport;
      logic [FlagByteW-1:0] flags;
   } pkt_type;

   // First-match result carried alongside the packet.
   typedef struct packed {
      logic                matched;
      logic [ActionW-1:0]  verdict;
      logic [RuleHitW-1:0] rule_hit;
   } hit_type;

endpackage : fmpf_pkg

`default_nettype wire

FILE: sv/fmpf_cell.sv
// One rule cell of the filter chain: holds one rule, tests the packet that
// passes through and hands packet and first-match result to its neighbour.
// Depends on fmpf_pkg.
`default_nettype none

module fmpf_cell
   import fmpf_pkg::*;
#(
   parameter logic [RuleHitW-1:0] HIT_INDEX = '0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   // Rule write
   input  wire logic     wr_en,
   input  wire rule_type wr_rule,
   // Cell lies below the rule count
   input  wire logic     enable,
   // From the previous cell
   input  wire logic     valid_prev,
   input  wire pkt_type  pkt_prev,
   input  wire hit_type  hit_prev,
   // To the next cell
   output logic          valid_next,
   output pkt_type       pkt_next,
   output hit_type       hit_next
);

   rule_type rule_ff, rule_in;
   logic     valid_ff;
   pkt_type  pkt_ff;
   hit_type  hit_ff, hit_in;

   logic addr_ok, proto_ok, src_ok, dst_ok, flags_ok, icmp_ok, rule_match;
   logic src_unset, dst_unset;

   // Rule storage is loaded only by a write transaction.
   assign rule_in = wr_en ? wr_rule : rule_ff;

   // Port ranges with a zero or inverted last port impose no constraint.
   assign src_unset = (rule_ff.src_last == '0) || (rule_ff.src_last < rule_ff.src_first);
   assign dst_unset = (rule_ff.dst_last == '0) || (rule_ff.dst_last < rule_ff.dst_first);
   assign src_ok    = src_unset || ((pkt_prev.sport >= rule_ff.src_first) &&
                                    (pkt_prev.sport <= rule_ff.src_last));
   assign dst_ok    = dst_unset || ((pkt_prev.dport >= rule_ff.dst_first) &&
                                    (pkt_prev.dport <= rule_ff.dst_last));

   assign addr_ok  = !rule_ff.check_address || (rule_ff.address == pkt_prev.address);
   assign proto_ok = (rule_ff.protocol == pkt_prev.protocol);
   assign flags_ok = ((rule_ff.flag_mask & pkt_prev.flags) == rule_ff.flag_match);
   assign icmp_ok  = (rule_ff.icmp_msg == '0) || (rule_ff.icmp_msg == pkt_prev.icmp_msg);

   // A rule with protocol "any" skips every test after the address.
   assign rule_match = addr_ok && ((rule_ff.protocol == ProtoAny) ||
                       (proto_ok && src_ok && dst_ok && flags_ok && icmp_ok));

   // An earlier hit is kept; otherwise this cell may claim the packet.
   always_comb begin
      hit_in = hit_prev;
      if (!hit_prev.matched && enable && rule_match) begin
         hit_in.matched  = 1'b1;
         hit_in.verdict  = rule_ff.action;
         hit_in.rule_hit = HIT_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      rule_ff <= rule_in;
      pkt_ff  <= pkt_prev;
      hit_ff  <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_prev;
      end
   end

   assign valid_next = valid_ff;
   assign pkt_next   = pkt_ff;
   assign hit_next   = hit_ff;

endmodule : fmpf_cell

`default_nettype wire

FILE: sv/first_match_packet_filter_top.sv
// First-match packet filter: a chain of RULE_SLOTS rule cells, one cell per cycle.
// An inspect packet passes the rule cells, the hold register and the output register to reach
// rsp_tvalid; a write answers through the hold and output registers. The input is ready again
// once the result sits in the output register, even while it waits there.
// Synchronous reset clears control state and rule_count; stored rules are undefined.
// Depends on fmpf_pkg and fmpf_cell.
`default_nettype none

module first_match_packet_filter_top
   import fmpf_pkg::*;
#(
   parameter int unsigned RULE_SLOTS = RuleSlotsDef
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Request stream
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // tdata from bit 0: rule_index, action, check_address, address, protocol,
   // ICMP type, src_first, src_last, dst_first, dst_last, TCP flags, zero pad
   input  wire logic [ReqDataW-1:0] req_tdata,
   // tuser: command
   input  wire logic                req_tuser,
   // Response stream
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // tdata from bit 0: verdict, matched, rule_hit, zero pad
   output logic [RspDataW-1:0]      rsp_tdata,
   // Configuration register: rule_count
   input  wire logic                csr_we,
   input  wire logic [CountW-1:0]   csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

   state_type           state_ff;
   logic                rsp_valid_ff;
   hit_type             rsp_hit_ff;
   hit_type             hold_hit_ff;
   logic [CountW-1:0]   rule_count_ff;

   logic                accept;
   logic                load_rsp;
   cmd_type             command;
   logic [RuleIndexW-1:0] rule_index;
   logic [ActionW-1:0]  req_action;
   logic [ProtocolW-1:0] req_protocol;
   logic [FlagsW-1:0]   req_flags;
   logic                is_l4;
   rule_type            wr_rule;
   pkt_type             inj_pkt;

   logic                valid_chain [0:RULE_SLOTS];
   pkt_type             pkt_chain   [0:RULE_SLOTS];
   hit_type             hit_chain   [0:RULE_SLOTS];

   // Request field extraction.
   assign accept       = req_tvalid && req_tready;
   assign command      = cmd_type'(req_tuser);
   assign rule_index   = req_tdata[OffRuleIndex +: RuleIndexW];
   assign req_action   = req_tdata[OffAction +: ActionW];
   assign req_protocol = req_tdata[OffProtocol +: ProtocolW];
   assign req_flags    = req_tdata[OffFlags +: FlagsW];

   // Rule image for a write transaction; action code three is stored as reject.
   always_comb begin
      wr_rule.action        = (req_action == ActSpare) ? ActReject : req_action;
      wr_rule.check_address = req_tdata[OffCheck];
      wr_rule.address       = req_tdata[OffAddress +: AddressW];
      wr_rule.protocol      = req_protocol;
      wr_rule.icmp_msg      = req_tdata[OffIcmp +: IcmpW];
      wr_rule.flag_mask     = req_flags[FlagsW-1 -: FlagByteW];
      wr_rule.flag_match    = req_flags[FlagByteW-1:0];
      wr_rule.src_first     = req_tdata[OffSrcFirst +: PortW];
      wr_rule.src_last      = req_tdata[OffSrcLast +: PortW];
      wr_rule.dst_first     = req_tdata[OffDstFirst +: PortW];
      wr_rule.dst_last      = req_tdata[OffDstLast +: PortW];
   end

   // Packet header gated by protocol before it enters the chain.
   assign is_l4 = (req_protocol == ProtoTcp) || (req_protocol == ProtoUdp);

   always_comb begin
      inj_pkt.address  = req_tdata[OffAddress +: AddressW];
      inj_pkt.protocol = req_protocol;
      inj_pkt.sport    = is_l4 ? req_tdata[OffSrcFirst +: PortW] : '0;
      inj_pkt.dport    = is_l4 ? req_tdata[OffDstFirst +: PortW] : '0;
      inj_pkt.flags    = (req_protocol == ProtoTcp) ? req_flags[FlagByteW-1:0] : '0;
      inj_pkt.icmp_msg = (req_protocol == ProtoIcmp) ? req_tdata[OffIcmp +: IcmpW] : '0;
   end

   // Head of the chain.
   assign valid_chain[0] = accept && (command == CMD_INSPECT);
   assign pkt_chain[0]   = inj_pkt;
   assign hit_chain[0]   = '0;

   // The row of rule cells.
   for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
      logic cell_wr;
      logic cell_en;

      assign cell_wr = accept && (command == CMD_WRITE) &&
                       (CountCmpW'(i) == CountCmpW'(rule_index));
      assign cell_en = (CountCmpW'(i) < CountCmpW'(rule_count_ff));

      fmpf_cell #(
         .HIT_INDEX (RuleHitW'(i))
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (cell_wr),
         .wr_rule    (wr_rule),
         .enable     (cell_en),
         .valid_prev (valid_chain[i]),
         .pkt_prev   (pkt_chain[i]),
         .hit_prev   (hit_chain[i]),
         .valid_next (valid_chain[i+1]),
         .pkt_next   (pkt_chain[i+1]),
         .hit_next   (hit_chain[i+1])
      );
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
      end else if (csr_we) begin
         rule_count_ff <= csr_wdata;
      end
   end

   // A held result moves to the output register once that register is free.
   assign load_rsp = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);

   // Transaction control and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            rsp_hit_ff   <= hold_hit_ff;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (command == CMD_WRITE) begin
                     hold_hit_ff <= '0;
                     state_ff    <= ST_HOLD;
                  end else begin
                     state_ff    <= ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               if (valid_chain[RULE_SLOTS]) begin
                  hold_hit_ff <= hit_chain[RULE_SLOTS];
                  state_ff    <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (load_rsp) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataW'({rsp_hit_ff.rule_hit, rsp_hit_ff.matched, rsp_hit_ff.verdict});

endmodule : first_match_packet_filter_top

`default_nettype wire
